// ----- rtl/assert_macros.svh -----
// Assertion macros used by the RTL top file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rstn, pre, post)
`define ASSERT_NEXT(label, clk, rstn, pre, post)
`endif
`endif

// ----- rtl/amc_rtb_pkg.sv -----
// Package with constants and types of the response time analysis block.
package amc_rtb_pkg;
    localparam int MAX_TASKS = 16;
    localparam int IDX_BITS = $clog2(MAX_TASKS);
    localparam int TIME_BITS = 32;
    localparam int RT_BITS = 40;
    localparam int ITER_LIMIT = 4096;
    localparam int ITER_BITS = $clog2(ITER_LIMIT + 1);
    localparam logic [RT_BITS-1:0] RT_SAT = '1;

    localparam logic [0:0] ACT_LOAD = 1'b0;
    localparam logic [0:0] ACT_ANALYZE = 1'b1;
    localparam logic [0:0] REG_MODE = 1'b0;
    localparam logic [0:0] REG_COUNT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD, ST_START, ST_CHECK, ST_TASK, ST_DIV, ST_MUL,
        ST_ACC, ST_NEXT, ST_DONE_LO, ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic busy;
    } div_ctl_t;
endpackage

// ----- rtl/amc_rtb_response_time_top.sv -----
// A load, or an analyze outside the task count, goes straight to the output state, where
// its item is registered once no earlier result waits. An analysis runs a division on the
// 40-step bit-serial divider per interfering entry, for up to 4096 iterations in each of
// the LO and HI phases.
// One item is in work at a time; a new item is taken while a result waits for the sink.
// Reset (synchronous, active low) clears control, mode to 1 and count to 0; table undefined.
`include "assert_macros.svh"
module amc_rtb_response_time_top
    import amc_rtb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_action,
    input  logic [3:0]           s_task_index,
    input  logic [31:0]          s_period,
    input  logic [31:0]          s_deadline,
    input  logic [31:0]          s_budget_lo,
    input  logic [31:0]          s_budget_hi,
    input  logic                 s_high_crit,
    input  logic [3:0]           s_prio_level,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [39:0]          m_response_time,
    output logic                 m_deadline_miss,
    output logic                 m_was_analysis,
    input  logic                 cfg_we,
    input  logic [0:0]           cfg_index,
    input  logic [4:0]           cfg_data
);
    logic [TIME_BITS-1:0] mem_period [MAX_TASKS];
    logic [TIME_BITS-1:0] mem_deadline [MAX_TASKS];
    logic [TIME_BITS-1:0] mem_blo [MAX_TASKS];
    logic [TIME_BITS-1:0] mem_bhi [MAX_TASKS];
    logic                 mem_high [MAX_TASKS];
    logic [3:0]           mem_prio [MAX_TASKS];

    state_t state_reg, state_next;
    logic mode_reg;
    logic [4:0] count_reg;
    logic [IDX_BITS-1:0] idx_reg, idx_next;
    logic [IDX_BITS:0] scan_reg, scan_next;
    logic hi_reg, hi_next;
    logic pend_an_reg, pend_an_next;
    logic [RT_BITS-1:0] cur_reg, cur_next, prev_reg, prev_next;
    logic [RT_BITS-1:0] acc_reg, acc_next, rlo_reg, rlo_next;
    logic [RT_BITS-1:0] prod_reg, prod_next;
    logic [ITER_BITS-1:0] iter_reg, iter_next;
    logic [TIME_BITS-1:0] own_dl_reg, own_blo_reg, own_bhi_reg;
    logic own_high_reg;
    logic [3:0] own_prio_reg;
    logic [TIME_BITS-1:0] t_per_reg, t_blo_reg, t_bhi_reg;
    logic t_high_reg;
    logic [3:0] t_prio_reg;
    logic out_valid_reg, out_valid_next;
    logic [RT_BITS-1:0] out_rt_reg, out_rt_next;
    logic out_miss_reg, out_miss_next, out_an_reg, out_an_next;
    logic [4:0] used;
    logic div_start;
    logic [RT_BITS-1:0] div_q;
    logic [RT_BITS-1:0] div_num;
    div_ctl_t div_ctl;
    logic t_hi_form;
    logic [TIME_BITS-1:0] t_budget;
    logic [RT_BITS+TIME_BITS-1:0] full_prod;
    logic [RT_BITS:0] sum;
    logic accept;

    assign used = (count_reg > 5'(MAX_TASKS)) ? 5'(MAX_TASKS) : count_reg;
    assign accept = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign t_hi_form = hi_reg && t_high_reg;
    assign div_num = (hi_reg && !t_high_reg) ? rlo_reg : prev_reg;
    assign t_budget = (t_hi_form) ? t_bhi_reg : t_blo_reg;
    assign full_prod = div_q * t_budget;
    assign sum = {1'b0, acc_reg} + {1'b0, prod_reg};

    amc_rtb_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(div_num), .divisor(t_per_reg), .ctl(div_ctl), .quot_ceil(div_q)
    );

    always_ff @(posedge aclk) begin
        if (accept && s_action == ACT_LOAD) begin
            mem_period[s_task_index] <= s_period;
            mem_deadline[s_task_index] <= s_deadline;
            mem_blo[s_task_index] <= s_budget_lo;
            mem_bhi[s_task_index] <= s_budget_hi;
            mem_high[s_task_index] <= s_high_crit;
            mem_prio[s_task_index] <= s_prio_level;
        end
        if (state_reg == ST_RD) begin
            own_dl_reg <= mem_deadline[idx_reg];
            own_blo_reg <= mem_blo[idx_reg];
            own_bhi_reg <= mem_bhi[idx_reg];
            own_high_reg <= mem_high[idx_reg];
            own_prio_reg <= mem_prio[idx_reg];
        end
        if (state_reg == ST_TASK) begin
            t_per_reg <= mem_period[scan_reg[IDX_BITS-1:0]];
            t_blo_reg <= mem_blo[scan_reg[IDX_BITS-1:0]];
            t_bhi_reg <= mem_bhi[scan_reg[IDX_BITS-1:0]];
            t_high_reg <= mem_high[scan_reg[IDX_BITS-1:0]];
            t_prio_reg <= mem_prio[scan_reg[IDX_BITS-1:0]];
        end
    end

    always_comb begin
        state_next = state_reg;
        idx_next = idx_reg;
        scan_next = scan_reg;
        hi_next = hi_reg;
        pend_an_next = pend_an_reg;
        cur_next = cur_reg;
        prev_next = prev_reg;
        acc_next = acc_reg;
        rlo_next = rlo_reg;
        prod_next = prod_reg;
        iter_next = iter_reg;
        out_valid_next = out_valid_reg;
        out_rt_next = out_rt_reg;
        out_miss_next = out_miss_reg;
        out_an_next = out_an_reg;
        div_start = 1'b0;
        if (out_valid_reg && m_ready) out_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    idx_next = s_task_index;
                    pend_an_next = (s_action == ACT_ANALYZE);
                    if (s_action == ACT_LOAD || 5'(s_task_index) >= used) begin
                        prod_next = '0;
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD: state_next = ST_START;
            ST_START: begin
                hi_next = 1'b0;
                cur_next = RT_BITS'(own_blo_reg);
                prev_next = '0;
                iter_next = '0;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                // Stop on a fixed point or once past the deadline; at the iteration limit, saturate.
                if (cur_reg == prev_reg || cur_reg > RT_BITS'(own_dl_reg)) begin
                    state_next = ST_DONE_LO;
                    prod_next = cur_reg;
                end else if (iter_reg == ITER_BITS'(ITER_LIMIT)) begin
                    state_next = ST_DONE_LO;
                    prod_next = RT_SAT;
                end else begin
                    prev_next = cur_reg;
                    acc_next = hi_reg ? RT_BITS'(own_bhi_reg) : RT_BITS'(own_blo_reg);
                    scan_next = '0;
                    iter_next = iter_reg + 1'b1;
                    state_next = ST_TASK;
                end
            end
            ST_TASK: begin
                if (scan_reg >= 5'(used)) begin
                    cur_next = acc_reg;
                    state_next = ST_CHECK;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (scan_reg[IDX_BITS-1:0] == idx_reg || t_prio_reg >= own_prio_reg) begin
                    state_next = ST_NEXT;
                end else begin
                    div_start = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (!div_ctl.busy && !div_ctl.start) begin
                    prod_next = (full_prod > (RT_BITS+TIME_BITS)'(RT_SAT)) ? RT_SAT
                                : full_prod[RT_BITS-1:0];
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                acc_next = sum[RT_BITS] ? RT_SAT : sum[RT_BITS-1:0];
                state_next = ST_NEXT;
            end
            ST_NEXT: begin
                scan_next = scan_reg + 1'b1;
                state_next = ST_TASK;
            end
            ST_DONE_LO: begin
                if (!hi_reg && mode_reg && own_high_reg) begin
                    hi_next = 1'b1;
                    rlo_next = prod_reg;
                    cur_next = prod_reg;
                    prev_next = '0;
                    iter_next = '0;
                    state_next = ST_CHECK;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!out_valid_reg) begin
                    out_valid_next = 1'b1;
                    out_rt_next = prod_reg;
                    out_miss_next = (prod_reg != '0) && (prod_reg > RT_BITS'(own_dl_reg));
                    out_an_next = pend_an_reg;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        scan_reg <= scan_next;
        hi_reg <= hi_next;
        pend_an_reg <= pend_an_next;
        cur_reg <= cur_next;
        prev_reg <= prev_next;
        acc_reg <= acc_next;
        rlo_reg <= rlo_next;
        prod_reg <= prod_next;
        iter_reg <= iter_next;
        out_rt_reg <= out_rt_next;
        out_miss_reg <= out_miss_next;
        out_an_reg <= out_an_next;
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
            mode_reg <= 1'b1;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && cfg_index == REG_MODE) mode_reg <= cfg_data[0];
            if (cfg_we && cfg_index == REG_COUNT) count_reg <= cfg_data;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_response_time = out_rt_reg;
    assign m_deadline_miss = out_miss_reg;
    assign m_was_analysis = out_an_reg;

    `ASSERT_IMPLIES(a_ready_idle, aclk, aresetn, s_ready, state_reg == ST_IDLE)
    `ASSERT_IMPLIES(a_miss_analysis, aclk, aresetn, m_valid && m_deadline_miss, m_was_analysis)
    `ASSERT_NEXT(a_load_ack, aclk, aresetn, accept && s_action == ACT_LOAD,
                 state_reg == ST_OUT && !pend_an_reg)
    `ASSERT_IMPLIES(a_iter_cap, aclk, aresetn, state_reg == ST_TASK,
                    iter_reg <= ITER_BITS'(ITER_LIMIT))
endmodule

// ----- rtl/amc_rtb_div.sv -----
// Radix-2 restoring divider that returns the ceiling of r over t.
module amc_rtb_div
    import amc_rtb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [RT_BITS-1:0]   dividend,
    input  logic [TIME_BITS-1:0] divisor,
    output div_ctl_t             ctl,
    output logic [RT_BITS-1:0]   quot_ceil
);
    localparam int CNT_BITS = $clog2(RT_BITS + 1);
    logic [RT_BITS-1:0] q_reg, q_next;
    logic [TIME_BITS:0] rem_reg, rem_next;
    logic [TIME_BITS-1:0] d_reg, d_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic [TIME_BITS:0] shifted;
    logic [TIME_BITS:0] diff;

    always_comb begin
        q_next = q_reg;
        rem_next = rem_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        shifted = {rem_reg[TIME_BITS-1:0], q_reg[RT_BITS-1]};
        diff = shifted - {1'b0, d_reg};
        if (start) begin
            q_next = dividend;
            rem_next = '0;
            d_next = (divisor == '0) ? TIME_BITS'(1) : divisor;
            cnt_next = CNT_BITS'(RT_BITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[TIME_BITS]) begin
                rem_next = diff;
                q_next = {q_reg[RT_BITS-2:0], 1'b1};
            end else begin
                rem_next = shifted;
                q_next = {q_reg[RT_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1)) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
        rem_reg <= rem_next;
        d_reg <= d_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    // The quotient reaches all ones only with a zero remainder, so the increment cannot wrap.
    assign quot_ceil = q_reg + RT_BITS'(rem_reg != '0);
    assign ctl.start = start;
    assign ctl.busy = busy_reg;
endmodule
